### hdl/ftws_pkg.sv
// Shared constants and command codes for the frame timing window statistics block.
package ftws_pkg;

  // Default width of the frame and duration counters.
  localparam int unsigned CounterWidthDef = 64;

  // Reset value of the nominal frame period, in nanoseconds.
  localparam logic [31:0] PeriodReset = 32'd1000000;

  // Input command codes.
  localparam logic [1:0] CmdRecord = 2'd0;
  localparam logic [1:0] CmdFold   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

endpackage

### hdl/frame_timing_window_stats_top.sv
// Frame timing window statistics with a restoring radix-2 divider for the window average.
// Record and clear items are taken without leaving the idle state, so the block stays ready for the next item.
// A baseline fold goes from idle straight to the finish state, which loads the output register, then back to idle.
// Other folds pass through the divide state and then the finish state before returning to idle.
// in_ready_o stays low while a fold is in progress or its result cannot enter the output register.
// rst_ni clears all statistics asynchronously and sets the period to 1000000 ns.
module frame_timing_window_stats_top
  import ftws_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = CounterWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Period register write port
  input  logic        period_we_i,
  input  logic [31:0] period_ns_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] tx_ns_i,
  input  logic [31:0] irq_count_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_first_o,
  output logic [63:0] frames_in_window_o,
  output logic [31:0] irqs_in_window_o,
  output logic [31:0] avg_ns_o,
  output logic [31:0] max_ns_o,
  output logic [31:0] slack_ns_o,
  output logic [31:0] late_irqs_o,
  output logic [63:0] backlog_total_o,
  output logic [63:0] worst_window_o
);

  localparam int unsigned CW   = COUNTER_WIDTH;
  localparam int unsigned CntW = $clog2(COUNTER_WIDTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [31:0]   period_q;
  logic [CW-1:0] frame_total_q, duration_total_q;
  logic [31:0]   duration_peak_q;
  logic          baseline_taken_q;
  logic [CW-1:0] prev_frame_total_q, prev_duration_total_q;
  logic [31:0]   prev_irq_count_q;
  logic [63:0]   backlog_sum_q, backlog_worst_q;
  logic          out_valid_q;

  // Divider and fold working registers
  logic [CW-1:0]   rem_q, quo_q, div_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     irq_delta_q;
  logic            first_q;

  // Output payload registers
  logic        is_first_q;
  logic [63:0] frames_out_q;
  logic [31:0] irqs_out_q, avg_out_q, max_out_q, headroom_out_q, late_out_q;
  logic [63:0] backlog_out_q, worst_out_q;

  logic in_acc, out_free, div_last, fin_fire;
  logic is_record, is_fold, is_clear;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign div_last   = (cnt_q == CntW'(CW - 1));
  assign fin_fire   = (state_q == StFin) && out_free;
  assign is_record  = in_acc && (cmd_i == CmdRecord);
  assign is_fold    = in_acc && (cmd_i == CmdFold);
  assign is_clear   = in_acc && (cmd_i == CmdClear);

  // One restoring division step: shift in the next dividend bit and try to subtract.
  logic [CW:0]   rem_sh;
  logic [CW+1:0] rem_sub;
  assign rem_sh  = {rem_q, quo_q[CW-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, div_q};

  // Window results from the finished division.
  logic [31:0] avg_w, headroom_w, late_w;
  logic        late_hit;
  logic [63:0] backlog_next, worst_next;
  always_comb begin
    avg_w        = (div_q != '0) ? quo_q[31:0] : 32'd0;
    headroom_w   = (avg_w < period_q) ? (period_q - avg_w) : 32'd0;
    late_hit     = CW'(irq_delta_q) > div_q;
    late_w       = late_hit ? (irq_delta_q - div_q[31:0]) : 32'd0;
    backlog_next = backlog_sum_q + 64'(late_w);
    worst_next   = (64'(late_w) > backlog_worst_q) ? 64'(late_w) : backlog_worst_q;
    if (first_q) begin
      avg_w        = 32'd0;
      headroom_w   = 32'd0;
      late_w       = 32'd0;
      backlog_next = backlog_sum_q;
      worst_next   = backlog_worst_q;
    end
  end

  // Sequencer: idle, divide (skipped for a baseline fold), then hand the result to the output register.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (is_fold) begin
          state_d = baseline_taken_q ? StDiv : StFin;
        end
      end
      StDiv: begin
        if (div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state and statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= StIdle;
      period_q              <= PeriodReset;
      frame_total_q         <= '0;
      duration_total_q      <= '0;
      duration_peak_q       <= '0;
      baseline_taken_q      <= 1'b0;
      prev_frame_total_q    <= '0;
      prev_duration_total_q <= '0;
      prev_irq_count_q      <= '0;
      backlog_sum_q         <= '0;
      backlog_worst_q       <= '0;
      out_valid_q           <= 1'b0;
      cnt_q                 <= '0;
    end else begin
      state_q <= state_d;
      if (period_we_i) begin
        period_q <= period_ns_i;
      end
      if (is_record && (tx_ns_i != 32'd0)) begin
        frame_total_q    <= frame_total_q + CW'(1);
        duration_total_q <= duration_total_q + CW'(tx_ns_i);
        if (tx_ns_i > duration_peak_q) begin
          duration_peak_q <= tx_ns_i;
        end
      end
      if (is_clear) begin
        frame_total_q         <= '0;
        duration_total_q      <= '0;
        duration_peak_q       <= '0;
        baseline_taken_q      <= 1'b0;
        prev_frame_total_q    <= '0;
        prev_duration_total_q <= '0;
        prev_irq_count_q      <= '0;
        backlog_sum_q         <= '0;
        backlog_worst_q       <= '0;
      end
      // Totals are frozen while a fold runs, so the baseline moves at acceptance.
      if (is_fold) begin
        prev_frame_total_q    <= frame_total_q;
        prev_duration_total_q <= duration_total_q;
        prev_irq_count_q      <= irq_count_i;
        baseline_taken_q      <= 1'b1;
        cnt_q                 <= '0;
      end else if (state_q == StDiv) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (fin_fire) begin
        backlog_sum_q   <= backlog_next;
        backlog_worst_q <= worst_next;
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider operands and output payload.
  always_ff @(posedge clk_i) begin
    if (is_fold) begin
      first_q     <= !baseline_taken_q;
      rem_q       <= '0;
      quo_q       <= duration_total_q - prev_duration_total_q;
      div_q       <= frame_total_q - prev_frame_total_q;
      irq_delta_q <= irq_count_i - prev_irq_count_q;
    end else if (state_q == StDiv) begin
      if (!rem_sub[CW+1]) begin
        rem_q <= rem_sub[CW-1:0];
        quo_q <= {quo_q[CW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CW-1:0];
        quo_q <= {quo_q[CW-2:0], 1'b0};
      end
    end
    if (fin_fire) begin
      is_first_q     <= first_q;
      frames_out_q   <= first_q ? 64'd0 : 64'(div_q);
      irqs_out_q     <= first_q ? 32'd0 : irq_delta_q;
      avg_out_q      <= avg_w;
      max_out_q      <= duration_peak_q;
      headroom_out_q <= headroom_w;
      late_out_q     <= late_w;
      backlog_out_q  <= backlog_next;
      worst_out_q    <= worst_next;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign is_first_o         = is_first_q;
  assign frames_in_window_o = frames_out_q;
  assign irqs_in_window_o   = irqs_out_q;
  assign avg_ns_o           = avg_out_q;
  assign max_ns_o           = max_out_q;
  assign slack_ns_o         = headroom_out_q;
  assign late_irqs_o        = late_out_q;
  assign backlog_total_o    = backlog_out_q;
  assign worst_window_o     = worst_out_q;

endmodule

### hdl/ftws_checker.sv
// Port-level checks for the frame timing window statistics block, bound to its top level.
module ftws_checker
  import ftws_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_first_o,
  input logic [63:0] frames_in_window_o,
  input logic [31:0] avg_ns_o,
  input logic [31:0] slack_ns_o,
  input logic [31:0] late_irqs_o,
  input logic [63:0] worst_window_o
);

  // A fold item keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CmdFold) |=> !in_ready_o)
    else $error("block ready right after a fold item");

  // A result that is not taken stays on the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frames_in_window_o)
      && $stable(avg_ns_o))
    else $error("pending result dropped or changed");

  // A baseline result carries no window figures.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_first_o |-> frames_in_window_o == 64'd0 && avg_ns_o == 32'd0
      && slack_ns_o == 32'd0 && late_irqs_o == 32'd0)
    else $error("baseline result carries window figures");

  // An empty window has a zero average.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frames_in_window_o == 64'd0) |-> avg_ns_o == 32'd0)
    else $error("nonzero average for an empty window");

  // The worst window is never below the current window's late count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> worst_window_o >= 64'(late_irqs_o))
    else $error("worst window below current late count");

endmodule

bind frame_timing_window_stats_top ftws_checker u_ftws_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .cmd_i              (cmd_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .is_first_o         (is_first_o),
  .frames_in_window_o (frames_in_window_o),
  .avg_ns_o           (avg_ns_o),
  .slack_ns_o         (slack_ns_o),
  .late_irqs_o        (late_irqs_o),
  .worst_window_o     (worst_window_o)
);
